FILE: rtl/ipfs_pkg.sv
package ipfs_pkg;

  // Input opcodes.
  localparam logic [2:0] OPC_START = 3'd0;
  localparam logic [2:0] OPC_READ  = 3'd1;
  localparam logic [2:0] OPC_WRITE = 3'd2;
  localparam logic [2:0] OPC_RESP  = 3'd3;
  localparam logic [2:0] OPC_RAW   = 3'd4;

  // Result kinds.
  localparam logic [2:0] KIND_FRAME      = 3'd0;
  localparam logic [2:0] KIND_READ_DATA  = 3'd1;
  localparam logic [2:0] KIND_VERIFIED   = 3'd2;
  localparam logic [2:0] KIND_UNVERIFIED = 3'd3;
  localparam logic [2:0] KIND_RAW_REPLY  = 3'd4;
  localparam logic [2:0] KIND_REJECTED   = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CLOCK_PERIOD  = 2'd0;
  localparam logic [1:0] CFG_POLL_BYTE_A   = 2'd1;
  localparam logic [1:0] CFG_POLL_BYTE_B   = 2'd2;
  localparam logic [1:0] CFG_WRITE_TIMEOUT = 2'd3;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);

  localparam logic [16:0] ElapsedMax = 17'h1ffff;
  localparam logic [7:0]  OddFlag    = 8'h08;
  localparam logic [7:0]  DirFlip    = 8'h60;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  mem_kind;
    logic [15:0] start_address;
    logic [7:0]  write_value;
    logic [31:0] raw_command;
    logic [31:0] target_reply;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] frame_out;
    logic [7:0]  read_value;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef enum logic [2:0] {
    CMD_START,
    CMD_READ,
    CMD_WRITE,
    CMD_RESP,
    CMD_RAW,
    CMD_BAD
  } cmd_op_e;

  // For start: {8'b0, command byte, address}; write: value in [7:0];
  // raw: the command word; response: the reply word.
  typedef struct packed {
    cmd_op_e     op;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  function automatic logic [7:0] mem_command(input logic [1:0] mk);
    logic [7:0] c;
    case (mk)
      2'd0:    c = 8'h20;
      2'd1:    c = 8'ha0;
      2'd2:    c = 8'h40;
      default: c = 8'hc0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/ipfs_front.sv
module ipfs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ipfs_pkg::in_item_t in_data_i,
  output ipfs_pkg::cmd_chan_t q_o,
  input  logic               q_ready_i
);
  import ipfs_pkg::*;

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  cmd_t                 cmd;
  logic                 push, pop;

  always_comb begin
    cmd.data = 32'd0;
    unique case (in_data_i.opcode)
      OPC_START: begin
        cmd.op   = CMD_START;
        cmd.data = {8'd0, mem_command(in_data_i.mem_kind), in_data_i.start_address};
      end
      OPC_READ: cmd.op = CMD_READ;
      OPC_WRITE: begin
        cmd.op   = CMD_WRITE;
        cmd.data = {24'd0, in_data_i.write_value};
      end
      OPC_RESP: begin
        cmd.op   = CMD_RESP;
        cmd.data = in_data_i.target_reply;
      end
      OPC_RAW: begin
        cmd.op   = CMD_RAW;
        cmd.data = in_data_i.raw_command;
      end
      default: cmd.op = CMD_BAD;
    endcase
  end

  assign in_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_o.valid  = (count_q != '0);
  assign q_o.cmd    = mem_q[rd_ptr_q];
  assign pop        = q_o.valid && q_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

FILE: rtl/ipfs_back.sv
module ipfs_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ipfs_pkg::cmd_chan_t                  q_i,
  output logic                                 q_ready_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output ipfs_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [ipfs_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [ipfs_pkg::CfgDataWidth-1:0]    cfg_data_i
);
  import ipfs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_READ,
    PH_WRITE,
    PH_POLL,
    PH_RAW
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] next_addr_q, next_addr_d;
  logic [7:0]  cmd_byte_q, cmd_byte_d;
  logic [23:0] head_q, head_d;
  logic [7:0]  last_wr_q, last_wr_d;
  logic [16:0] elapsed_q, elapsed_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic [7:0]  clock_period_q;
  logic [7:0]  poll_a_q;
  logic [7:0]  poll_b_q;
  logic [15:0] timeout_q;

  logic        take;
  logic        emit;
  out_item_t   res;
  logic [15:0] addr;
  logic [7:0]  c0;
  logic [23:0] head;
  logic [7:0]  reply;
  logic [17:0] elapsed_sum;
  logic [16:0] elapsed_sat;

  assign take      = q_i.valid && (!out_valid_q || out_ready_i);
  assign q_ready_o = take;

  // Frame head built from the running address and the command byte.
  always_comb begin
    addr = cmd_byte_q[7] ? {next_addr_q[14:0], 1'b0} : next_addr_q;
    c0   = addr[0] ? (cmd_byte_q | OddFlag) : cmd_byte_q;
    head = {c0, 1'b0, addr[15:9], addr[8:1]};
  end

  assign reply       = q_i.cmd.data[7:0];
  assign elapsed_sum = {1'b0, elapsed_q} + {5'd0, clock_period_q, 5'd0};
  assign elapsed_sat = elapsed_sum[17] ? ElapsedMax : elapsed_sum[16:0];

  always_comb begin
    phase_d     = phase_q;
    next_addr_d = next_addr_q;
    cmd_byte_d  = cmd_byte_q;
    head_d      = head_q;
    last_wr_d   = last_wr_q;
    elapsed_d   = elapsed_q;
    emit        = 1'b0;
    res         = '{kind: KIND_REJECTED, frame_out: 32'd0, read_value: 8'd0};

    unique case (q_i.cmd.op)
      CMD_START: begin
        cmd_byte_d  = q_i.cmd.data[23:16];
        next_addr_d = q_i.cmd.data[15:0];
        phase_d     = PH_IDLE;
      end
      CMD_READ, CMD_WRITE, CMD_RAW: begin
        emit = 1'b1;
        if (phase_q == PH_IDLE) begin
          res.kind = KIND_FRAME;
          if (q_i.cmd.op == CMD_RAW) begin
            res.frame_out = q_i.cmd.data;
            phase_d       = PH_RAW;
          end else begin
            next_addr_d = next_addr_q + 16'd1;
            if (q_i.cmd.op == CMD_WRITE) begin
              last_wr_d     = q_i.cmd.data[7:0];
              res.frame_out = {head, q_i.cmd.data[7:0]};
              head_d        = head ^ {DirFlip, 16'd0};
              phase_d       = PH_WRITE;
            end else begin
              res.frame_out = {head, last_wr_q};
              head_d        = head;
              phase_d       = PH_READ;
            end
          end
        end
      end
      CMD_RESP: begin
        emit    = 1'b1;
        phase_d = PH_IDLE;
        case (phase_q)
          PH_READ: begin
            res.kind       = KIND_READ_DATA;
            res.read_value = reply;
          end
          PH_RAW: begin
            res.kind      = KIND_RAW_REPLY;
            res.frame_out = q_i.cmd.data;
          end
          PH_WRITE: begin
            elapsed_d = '0;
            if (timeout_q == 16'd0) begin
              res.kind = KIND_UNVERIFIED;
            end else begin
              res.kind      = KIND_FRAME;
              res.frame_out = {head_q, last_wr_q};
              phase_d       = PH_POLL;
            end
          end
          PH_POLL: begin
            if (reply == last_wr_q && reply != poll_a_q && reply != poll_b_q) begin
              res.kind = KIND_VERIFIED;
            end else begin
              elapsed_d = elapsed_sat;
              if (elapsed_sat < {1'b0, timeout_q}) begin
                res.kind      = KIND_FRAME;
                res.frame_out = {head_q, last_wr_q};
                phase_d       = PH_POLL;
              end else begin
                res.kind = KIND_UNVERIFIED;
              end
            end
          end
          default: res.kind = KIND_REJECTED;
        endcase
      end
      default: emit = 1'b1;
    endcase

    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (take && emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      next_addr_q <= '0;
      cmd_byte_q  <= '0;
      head_q      <= '0;
      last_wr_q   <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        phase_q     <= phase_d;
        next_addr_q <= next_addr_d;
        cmd_byte_q  <= cmd_byte_d;
        head_q      <= head_d;
        last_wr_q   <= last_wr_d;
        elapsed_q   <= elapsed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_period_q <= 8'd10;
      poll_a_q       <= 8'hff;
      poll_b_q       <= 8'hff;
      timeout_q      <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLOCK_PERIOD:  clock_period_q <= cfg_data_i[7:0];
        CFG_POLL_BYTE_A:   poll_a_q       <= cfg_data_i[7:0];
        CFG_POLL_BYTE_B:   poll_b_q       <= cfg_data_i[7:0];
        CFG_WRITE_TIMEOUT: timeout_q      <= cfg_data_i;
        default:           timeout_q      <= timeout_q;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/isp_program_frame_sequencer_unit.sv
// Serial-programming frame sequencer.
// Input channel (in_valid_i/in_ready_o/in_data_i): start, read byte, write byte,
// target response and raw frame items. Output channel (out_valid_o/out_ready_i/
// out_data_o): at most one result per item: a frame to send, read data, a write
// verdict, a raw reply or a rejection. A start item produces no result.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
// do so only while idle, as the block itself does not enforce it. An accepted
// item is held in the command queue, then executed into the output register.
// Throughput: one item per cycle unless the receiver stalls. A front stage
// decodes items into a two-entry command queue; the back stage executes one
// queued command per cycle into the output register, setting the rate.
// Reset clears the queue, the sequencing state, the output valid flag and the
// configuration to its defaults.
// When the receiver stalls, the output register holds its result, the back stage
// stops draining the queue, and in_ready_o drops once both queue entries fill.
module isp_program_frame_sequencer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ipfs_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ipfs_pkg::out_item_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [ipfs_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [ipfs_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  import ipfs_pkg::*;

  cmd_chan_t q_chan;
  logic      q_ready;

  ipfs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_o        (q_chan),
    .q_ready_i  (q_ready)
  );

  ipfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (q_chan),
    .q_ready_o   (q_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

FILE: rtl/ipfs_checker.sv
module ipfs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ipfs_pkg::out_item_t out_data_o
);
  import ipfs_pkg::*;

  // A pending result must stay put until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // No result may be offered while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  // Only defined result kinds leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.kind <= KIND_REJECTED)
    else $error("undefined result kind");

  // Read data appears only on read results, and frame words only on frames
  // and raw replies.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_READ_DATA |-> out_data_o.read_value == 8'd0)
    else $error("stray read data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_FRAME && out_data_o.kind != KIND_RAW_REPLY
    |-> out_data_o.frame_out == 32'd0)
    else $error("stray frame word");

endmodule

bind isp_program_frame_sequencer_unit ipfs_checker u_ipfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
